@@ sv/lcsm_pkg.sv @@
// ----------------------------------------------------------------------------
// lcsm_pkg
// Shared types and codes for the link connection state machine.
// ----------------------------------------------------------------------------
package lcsm_pkg;

	typedef enum logic [1:0] {
		MODE_LISTEN    = 2'd0,
		MODE_SYNC      = 2'd1,
		MODE_CONNECTED = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ACT_WAIT     = 2'd0,
		ACT_RECEIVE  = 2'd1,
		ACT_TRANSMIT = 2'd2
	} action_t;

	// operation codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SLOT = 1'b1;

	// receive status codes
	localparam logic [1:0] RX_NONE    = 2'd0;
	localparam logic [1:0] RX_INVALID = 2'd1;
	localparam logic [1:0] RX_HDR_OK  = 2'd2;
	localparam logic [1:0] RX_VALID   = 2'd3;

	// antenna modes
	localparam logic [1:0] ANT_ONE  = 2'd0;
	localparam logic [1:0] ANT_TWO  = 2'd1;
	localparam logic [1:0] ANT_BOTH = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FRAMES  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOP_SLOTS    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANTENNA_MODE = 8'd3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0] CNT8_MAX = 8'hFF;

	typedef struct packed {
		logic [7:0]  sync_frames_needed;
		logic [15:0] timeout_ticks;
		logic [7:0]  listen_hop_slots;
		logic [1:0]  antenna_mode;
	} cfg_t;

	typedef struct packed {
		mode_t       link_mode;
		logic [7:0]  sync_count;
		logic [15:0] timeout_count;
		logic [7:0]  listen_count;
		logic        reached_connected;
	} state_t;

	typedef struct packed {
		mode_t   link_condition;
		action_t link_action;
		logic    hop_now;
		logic    slot_missed;
		logic    radio_idle;
		logic    ever_connected;
		logic    valid_seen;
	} result_t;

endpackage

@@ sv/link_connect_state_machine.sv @@
// ----------------------------------------------------------------------------
// link_connect_state_machine: receiver link connection manager
// Result path: input transfer to the input register, then to the result register.
// Throughput: 1 item per cycle unless out_ready stalls; link state updates per item.
// Reset: link in listen, counters zero, registers at defaults, pipeline empty.
// ----------------------------------------------------------------------------
module link_connect_state_machine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcsm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [1:0]                        rx1_status,
	input  logic [1:0]                        rx2_status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        link_condition,
	output logic [1:0]                        link_action,
	output logic                              hop_now,
	output logic                              slot_missed,
	output logic                              radio_idle,
	output logic                              ever_connected,
	output logic                              valid_seen
);
	import lcsm_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_next;
	result_t result_next;
	result_t result_q;
	logic    out_valid_q;

	logic       valid_s1;
	logic       operation_s1;
	logic [1:0] rx1_s1;
	logic [1:0] rx2_s1;
	logic       advance_s1;

	assign cfg_ready  = 1'b1;
	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_frames_needed <= 8'd5;
			cfg_q.timeout_ticks      <= 16'd500;
			cfg_q.listen_hop_slots   <= 8'd10;
			cfg_q.antenna_mode       <= ANT_ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SYNC_FRAMES:  cfg_q.sync_frames_needed <= cfg_data[7:0];
				CFG_TIMEOUT:      cfg_q.timeout_ticks      <= cfg_data[15:0];
				CFG_HOP_SLOTS:    cfg_q.listen_hop_slots   <= cfg_data[7:0];
				CFG_ANTENNA_MODE: cfg_q.antenna_mode       <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			operation_s1 <= operation;
			rx1_s1       <= rx1_status;
			rx2_s1       <= rx2_status;
		end
	end

	lcsm_step u_step (
		.cfg        (cfg_q),
		.state      (state_q),
		.operation  (operation_s1),
		.rx1_status (rx1_s1),
		.rx2_status (rx2_s1),
		.state_next (state_next),
		.result     (result_next)
	);

	// link state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{link_mode: MODE_LISTEN, default: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (advance_s1) begin
				state_q     <= state_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1)
			result_q <= result_next;
	end

	assign out_valid      = out_valid_q;
	assign link_condition = result_q.link_condition;
	assign link_action    = result_q.link_action;
	assign hop_now        = result_q.hop_now;
	assign slot_missed    = result_q.slot_missed;
	assign radio_idle     = result_q.radio_idle;
	assign ever_connected = result_q.ever_connected;
	assign valid_seen     = result_q.valid_seen;

endmodule

@@ sv/lcsm_step.sv @@
// ----------------------------------------------------------------------------
// lcsm_step
// Next-state and result logic for one tick or slot item.
// ----------------------------------------------------------------------------
module lcsm_step (
	input  lcsm_pkg::cfg_t    cfg,
	input  lcsm_pkg::state_t  state,
	input  logic              operation,
	input  logic [1:0]        rx1_status,
	input  logic [1:0]        rx2_status,
	output lcsm_pkg::state_t  state_next,
	output lcsm_pkg::result_t result
);
	import lcsm_pkg::*;

	logic        frame_ok;
	logic        frame_bad;
	logic [1:0]  sel_status;

	// combine antennas
	always_comb begin
		sel_status = (cfg.antenna_mode == ANT_TWO) ? rx2_status : rx1_status;
		if (cfg.antenna_mode >= ANT_BOTH) begin
			frame_ok  = (rx1_status >= RX_HDR_OK) || (rx2_status >= RX_HDR_OK);
			frame_bad = ((rx1_status != RX_NONE) || (rx2_status != RX_NONE)) && !frame_ok;
		end else begin
			frame_ok  = (sel_status >= RX_HDR_OK);
			frame_bad = (sel_status == RX_INVALID);
		end
	end

	always_comb begin
		state_next = state;
		result     = '0;

		if (operation == OP_TICK) begin
			if (state.timeout_count != '0)
				state_next.timeout_count = state.timeout_count - 16'd1;
		end else begin
			if (frame_ok) begin
				if (state.link_mode == MODE_LISTEN) begin
					state_next.link_mode  = MODE_SYNC;
					state_next.sync_count = '0;
				end else if (state.link_mode == MODE_SYNC) begin
					if (state.sync_count != CNT8_MAX)
						state_next.sync_count = state.sync_count + 8'd1;
					if (state_next.sync_count >= cfg.sync_frames_needed) begin
						state_next.link_mode         = MODE_CONNECTED;
						state_next.reached_connected = 1'b1;
					end
				end
				state_next.timeout_count = cfg.timeout_ticks;
				result.link_action       = ACT_TRANSMIT;
			end

			if (state_next.link_mode == MODE_LISTEN && frame_bad)
				result.link_action = ACT_RECEIVE;

			// listen dwell
			if (state_next.link_mode == MODE_LISTEN) begin
				if (state.listen_count != CNT8_MAX)
					state_next.listen_count = state.listen_count + 8'd1;
				if (state_next.listen_count >= cfg.listen_hop_slots) begin
					result.hop_now          = 1'b1;
					state_next.listen_count = '0;
					result.link_action      = ACT_RECEIVE;
				end
			end

			// timeout drops back to listen
			if (state_next.link_mode != MODE_LISTEN && state_next.timeout_count == '0) begin
				state_next.link_mode    = MODE_LISTEN;
				state_next.listen_count = '0;
				result.link_action      = ACT_RECEIVE;
			end

			if (state_next.link_mode != MODE_LISTEN && !frame_ok) begin
				result.slot_missed = 1'b1;
				result.link_action = ACT_TRANSMIT;
			end

			result.radio_idle = (state_next.link_mode != MODE_LISTEN) ||
				(result.link_action != ACT_WAIT);
			result.valid_seen = frame_ok;
		end

		result.link_condition = state_next.link_mode;
		result.ever_connected = state_next.reached_connected;
	end

endmodule

@@ sim/tb_link_connect_state_machine.sv @@
// ----------------------------------------------------------------------------
// tb_link_connect_state_machine
// Self-checking bench for the link connection manager. A driver feeds tick and
// slot events from a queue, a shadow model of the link state predicts each
// result, and a monitor checks every result transfer field by field. Phases
// step through register settings and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_link_connect_state_machine;
	timeunit 1ns;
	timeprecision 1ps;

	import lcsm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 4;

	typedef struct packed {
		logic       op;
		logic [1:0] rx1;
		logic [1:0] rx2;
	} slot_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  operation = OP_TICK;
	logic [1:0]            rx1_status = RX_NONE;
	logic [1:0]            rx2_status = RX_NONE;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            link_condition;
	logic [1:0]            link_action;
	logic                  hop_now;
	logic                  slot_missed;
	logic                  radio_idle;
	logic                  ever_connected;
	logic                  valid_seen;

	slot_event_t pending_events[$];
	result_t     predicted_results[$];

	// shadow copy of registers and link state
	cfg_t   reg_shadow;
	state_t link_shadow;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_off_left = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	link_connect_state_machine DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.rx1_status     (rx1_status),
		.rx2_status     (rx2_status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.link_condition (link_condition),
		.link_action    (link_action),
		.hop_now        (hop_now),
		.slot_missed    (slot_missed),
		.radio_idle     (radio_idle),
		.ever_connected (ever_connected),
		.valid_seen     (valid_seen)
	);

	always #2 clk = ~clk;

	// Advance the shadow link state by one event and return the result it yields.
	function automatic result_t advance_link(input slot_event_t ev);
		result_t    r;
		action_t    act;
		logic       frame_ok;
		logic       frame_bad;
		logic       heard;
		logic       hop;
		logic       missed;
		logic       idle;
		logic [1:0] st;
		act = ACT_WAIT;
		frame_ok = 1'b0;
		frame_bad = 1'b0;
		hop = 1'b0;
		missed = 1'b0;
		idle = 1'b0;
		if (ev.op == OP_TICK) begin
			if (link_shadow.timeout_count != 16'd0)
				link_shadow.timeout_count = link_shadow.timeout_count - 16'd1;
		end else begin
			// mode 3 behaves as both antennas
			if (reg_shadow.antenna_mode >= ANT_BOTH) begin
				heard = (ev.rx1 != RX_NONE) || (ev.rx2 != RX_NONE);
				frame_ok = (ev.rx1 >= RX_HDR_OK) || (ev.rx2 >= RX_HDR_OK);
				frame_bad = heard && !frame_ok;
			end else begin
				st = (reg_shadow.antenna_mode == ANT_TWO) ? ev.rx2 : ev.rx1;
				frame_ok = (st >= RX_HDR_OK);
				frame_bad = (st == RX_INVALID);
			end

			if (frame_ok) begin
				if (link_shadow.link_mode == MODE_LISTEN) begin
					link_shadow.link_mode = MODE_SYNC;
					link_shadow.sync_count = 8'd0;
				end else if (link_shadow.link_mode == MODE_SYNC) begin
					if (link_shadow.sync_count != CNT8_MAX)
						link_shadow.sync_count = link_shadow.sync_count + 8'd1;
					if (link_shadow.sync_count >= reg_shadow.sync_frames_needed) begin
						link_shadow.link_mode = MODE_CONNECTED;
						link_shadow.reached_connected = 1'b1;
					end
				end
				link_shadow.timeout_count = reg_shadow.timeout_ticks;
				act = ACT_TRANSMIT;
			end

			if (link_shadow.link_mode == MODE_LISTEN && frame_bad)
				act = ACT_RECEIVE;

			if (link_shadow.link_mode == MODE_LISTEN) begin
				if (link_shadow.listen_count != CNT8_MAX)
					link_shadow.listen_count = link_shadow.listen_count + 8'd1;
				if (link_shadow.listen_count >= reg_shadow.listen_hop_slots) begin
					hop = 1'b1;
					link_shadow.listen_count = 8'd0;
					act = ACT_RECEIVE;
				end
			end

			if (link_shadow.link_mode >= MODE_SYNC && link_shadow.timeout_count == 16'd0) begin
				link_shadow.link_mode = MODE_LISTEN;
				link_shadow.listen_count = 8'd0;
				act = ACT_RECEIVE;
			end

			if (link_shadow.link_mode >= MODE_SYNC && !frame_ok) begin
				missed = 1'b1;
				act = ACT_TRANSMIT;
			end

			idle = (link_shadow.link_mode >= MODE_SYNC) || (act != ACT_WAIT);
		end
		r.link_condition = link_shadow.link_mode;
		r.link_action = act;
		r.hop_now = hop;
		r.slot_missed = missed;
		r.radio_idle = idle;
		r.ever_connected = link_shadow.reached_connected;
		r.valid_seen = frame_ok;
		return r;
	endfunction

	// Event driver: offers the head of the pending queue, predicts on transfer.
	always @(posedge clk) begin
		logic offering;
		if (arst_n) begin
			offering = in_valid;
			if (in_valid && in_ready) begin
				predicted_results.push_back(advance_link('{operation, rx1_status, rx2_status}));
				void'(pending_events.pop_front());
				offering = 1'b0;
			end
			if (!offering) begin
				if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					operation <= pending_events[0].op;
					rx1_status <= pending_events[0].rx1;
					rx2_status <= pending_events[0].rx2;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(input string field, input logic [1:0] want,
			input logic [1:0] got);
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		fail_count++;
	endtask

	// Result monitor and receiver back-pressure.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t ns: result transfer with nothing expected, expected none, got %0d",
						$time, link_condition);
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					if (link_condition !== want.link_condition)
						report_mismatch("link_condition", want.link_condition, link_condition);
					if (link_action !== want.link_action)
						report_mismatch("link_action", want.link_action, link_action);
					if (hop_now !== want.hop_now)
						report_mismatch("hop_now", {1'b0, want.hop_now}, {1'b0, hop_now});
					if (slot_missed !== want.slot_missed)
						report_mismatch("slot_missed", {1'b0, want.slot_missed},
							{1'b0, slot_missed});
					if (radio_idle !== want.radio_idle)
						report_mismatch("radio_idle", {1'b0, want.radio_idle},
							{1'b0, radio_idle});
					if (ever_connected !== want.ever_connected)
						report_mismatch("ever_connected", {1'b0, want.ever_connected},
							{1'b0, ever_connected});
					if (valid_seen !== want.valid_seen)
						report_mismatch("valid_seen", {1'b0, want.valid_seen},
							{1'b0, valid_seen});
				end
			end
			if (hold_off_left != 0) begin
				out_ready <= 1'b0;
				hold_off_left <= hold_off_left - 1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SYNC_FRAMES:  reg_shadow.sync_frames_needed = val[7:0];
			CFG_TIMEOUT:      reg_shadow.timeout_ticks = val;
			CFG_HOP_SLOTS:    reg_shadow.listen_hop_slots = val[7:0];
			CFG_ANTENNA_MODE: reg_shadow.antenna_mode = val[1:0];
			default: ;
		endcase
	endtask

	task automatic load_regs(input logic [7:0] sync_need, input logic [15:0] tmo,
			input logic [7:0] hop_slots, input logic [1:0] ant);
		write_reg(CFG_SYNC_FRAMES, {8'd0, sync_need});
		write_reg(CFG_TIMEOUT, tmo);
		write_reg(CFG_HOP_SLOTS, {8'd0, hop_slots});
		write_reg(CFG_ANTENNA_MODE, {14'd0, ant});
	endtask

	// wait until every queued event is sent and every result has come back
	task automatic drain();
		@(negedge clk);
		while (pending_events.size() != 0 || predicted_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [1:0] good_status(input int unsigned good_pct);
		if ($urandom_range(99) < good_pct)
			return $urandom_range(1) ? RX_VALID : RX_HDR_OK;
		return 2'($urandom_range(3));
	endfunction

	// Mostly link traffic with good frames, plus tick runs of up to timeout_ticks + 3
	// events (capped at 40) and some fully random events.
	task automatic queue_random(input int unsigned count, input int unsigned good_pct);
		int unsigned kind;
		int unsigned run;
		int unsigned run_max;
		slot_event_t ev;
		@(negedge clk);
		run_max = (reg_shadow.timeout_ticks + 3 < 40) ? reg_shadow.timeout_ticks + 3 : 40;
		while (count != 0) begin
			kind = $urandom_range(99);
			if (kind < 12) begin
				run = $urandom_range(run_max, 1);
				while (run != 0 && count != 0) begin
					pending_events.push_back('{OP_TICK, 2'($urandom_range(3)),
						2'($urandom_range(3))});
					run--;
					count--;
				end
			end else begin
				if (kind < 27)
					ev = '{1'($urandom_range(1)), 2'($urandom_range(3)), 2'($urandom_range(3))};
				else
					ev = '{($urandom_range(99) < 20) ? OP_TICK : OP_SLOT,
						good_status(good_pct), good_status(good_pct)};
				pending_events.push_back(ev);
				count--;
			end
		end
	endtask

	initial begin
		reg_shadow = '{sync_frames_needed: 8'd5, timeout_ticks: 16'd500,
			listen_hop_slots: 8'd10, antenna_mode: ANT_ONE};
		link_shadow = '{link_mode: MODE_LISTEN, sync_count: 8'd0, timeout_count: 16'd0,
			listen_count: 8'd0, reached_connected: 1'b0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset registers, antenna one only
		@(negedge clk);
		pending_events.push_back('{OP_TICK, RX_VALID, RX_VALID});    // timeout already at zero
		pending_events.push_back('{OP_SLOT, RX_NONE, RX_VALID});     // other antenna ignored
		pending_events.push_back('{OP_SLOT, RX_INVALID, RX_NONE});   // re-arm receive
		pending_events.push_back('{OP_SLOT, RX_HDR_OK, RX_INVALID}); // enter sync
		repeat (5) pending_events.push_back('{OP_SLOT, RX_VALID, RX_NONE});
		pending_events.push_back('{OP_SLOT, RX_NONE, RX_VALID});     // missed while connected
		pending_events.push_back('{OP_SLOT, RX_INVALID, RX_HDR_OK});
		pending_events.push_back('{OP_TICK, RX_NONE, RX_NONE});
		pending_events.push_back('{OP_TICK, RX_INVALID, RX_HDR_OK});
		pending_events.push_back('{OP_SLOT, RX_VALID, RX_VALID});
		drain();

		// lowest nonzero settings, both antennas, sender idling
		load_regs(8'd1, 16'd1, 8'd1, ANT_BOTH);
		send_idle_pct = 68;
		queue_random(200, 60);
		drain();   // sender pauses until everything is back
		queue_random(200, 60);
		drain();

		// highest settings, antenna two, receiver stalling
		load_regs(8'hFF, 16'hFFFF, 8'hFF, ANT_TWO);
		send_idle_pct = 0;
		recv_stall_pct = 68;
		queue_random(400, 90);
		drain();

		// zero registers and antenna mode three, light idling on both sides
		load_regs(8'd0, 16'd0, 8'd0, 2'd3);
		send_idle_pct = 7;
		recv_stall_pct = 7;
		queue_random(400, 50);
		drain();

		// mid settings, full rate with a long receiver hold-off to fill the block
		load_regs(8'd3, 16'd20, 8'd4, ANT_ONE);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_off_left = 300;
		queue_random(400, 70);
		drain();

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lcsm_pkg.sv
sv/lcsm_step.sv
sv/link_connect_state_machine.sv
sim/tb_link_connect_state_machine.sv
